### rtl/gcpf_pkg.sv
`timescale 1ns / 1ps

package gcpf_pkg;

    // Field widths fixed by the interface.
    localparam int PITCH_W  = 18;
    localparam int GYRO_W   = 20;
    localparam int DT_W     = 16;
    localparam int NORM_W   = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Shared multiplier operand and result widths.
    localparam int MUL_A_W = 21;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = MUL_P_W + 1;
    localparam int WIDE_W  = 24;

    // Fixed-point constants.
    localparam logic [CFG_W-1:0]  ALPHA_DEFAULT = 16'd64225;
    localparam logic [DT_W-1:0]   DT_LIMIT      = 16'd6553;
    localparam logic [NORM_W-1:0] NORM_ONE      = 16'd4096;
    localparam logic [16:0]       WEIGHT_ONE    = 17'h10000;

    localparam logic signed [PITCH_W-1:0] PITCH_MAX = 18'sh1FFFF;
    localparam logic signed [PITCH_W-1:0] PITCH_MIN = 18'sh20000;

    // Action codes.
    localparam logic [1:0] ACT_GATED = 2'd0;
    localparam logic [1:0] ACT_PLAIN = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd2;

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_SUM    = 7'b0000100,
        ST_MIX1   = 7'b0001000,
        ST_MIX2   = 7'b0010000,
        ST_FIN    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    // Saturate a wide signed value to the pitch range.
    function automatic logic signed [PITCH_W-1:0] sat_pitch(input logic signed [WIDE_W-1:0] v);
        logic signed [PITCH_W-1:0] r;
        if (v > WIDE_W'(PITCH_MAX))
            r = PITCH_MAX;
        else if (v < WIDE_W'(PITCH_MIN))
            r = PITCH_MIN;
        else
            r = v[PITCH_W-1:0];
        return r;
    endfunction

endpackage

### rtl/gated_complementary_pitch_filter.sv
`timescale 1ns / 1ps

// A full blend steps through DECODE, SUM, MIX1, MIX2, FIN and OUT; a load, an unused
// action or a bad interval goes from DECODE straight to OUT, a gyro-only step from SUM.
// A new beat is taken only back in IDLE, and OUT waits while the output stalls. The
// single shared 21x18 multiplier is used in DECODE, MIX1 and MIX2 of a blend.
// Reset (rst_n, asynchronous, active low) clears pitch and deadline to zero and loads
// the register defaults: alpha 64225, threshold 410, hold 200 ms.
module gated_complementary_pitch_filter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            action,
    input  logic signed [gcpf_pkg::GYRO_W-1:0]    gyro_rate,
    input  logic signed [gcpf_pkg::PITCH_W-1:0]   accel_pitch,
    input  logic [gcpf_pkg::DT_W-1:0]             step_time,
    input  logic [gcpf_pkg::NORM_W-1:0]           accel_norm,
    input  logic [gcpf_pkg::TIME_W-1:0]           now_time,
    input  logic signed [gcpf_pkg::PITCH_W-1:0]   start_pitch,
    // Output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [gcpf_pkg::PITCH_W-1:0]   pitch_estimate,
    output logic                                  gyro_only,
    output logic                                  interval_fault,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gcpf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gcpf_pkg::CFG_W-1:0]            cfg_data
);

    import gcpf_pkg::*;

    // Control and state registers.
    state_t                      state_reg, state_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [PITCH_W-1:0]   pitch_reg, pitch_next;
    logic [TIME_W-1:0]           deadline_reg, deadline_next;
    logic [CFG_W-1:0]            alpha_reg, alpha_next;
    logic [CFG_W-1:0]            thresh_reg, thresh_next;
    logic [CFG_W-1:0]            hold_reg, hold_next;

    // Captured input beat.
    logic [1:0]                  action_reg;
    logic signed [GYRO_W-1:0]    gyro_reg;
    logic signed [PITCH_W-1:0]   accel_reg;
    logic [DT_W-1:0]             dt_reg;
    logic [NORM_W-1:0]           norm_reg;
    logic [TIME_W-1:0]           now_reg;
    logic signed [PITCH_W-1:0]   start_reg;

    // Datapath registers.
    logic signed [MUL_P_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [MUL_A_W-1:0]   sum_reg, sum_next;
    logic                        gyro_flag_reg, gyro_flag_next;
    logic                        fault_flag_reg, fault_flag_next;

    // Output payload registers.
    logic signed [PITCH_W-1:0]   pitch_out_reg;
    logic                        gyro_out_reg;
    logic                        fault_out_reg;

    // Shared multiplier and helpers.
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0]   mul_p;
    logic [CFG_W-1:0]            alpha_eff;
    logic [16:0]                 accel_weight;
    logic signed [WIDE_W-1:0]    sum_wide;
    logic signed [ACC_W-1:0]     mix;
    logic [NORM_W-1:0]           norm_err;
    logic [TIME_W-1:0]           deadline_cand;
    logic                        hold_active;
    logic                        dt_bad;
    logic                        in_beat;
    logic                        out_free;

    assign in_stall       = (state_reg != ST_IDLE);
    assign in_beat        = in_valid && !in_stall;
    assign out_valid      = out_valid_reg;
    assign pitch_estimate = pitch_out_reg;
    assign gyro_only      = gyro_out_reg;
    assign interval_fault = fault_out_reg;
    assign cfg_ready      = 1'b1;
    assign out_free       = !out_valid_reg || !out_stall;

    // Effective blend weights.
    assign alpha_eff    = (alpha_reg == '0) ? ALPHA_DEFAULT : alpha_reg;
    assign accel_weight = WEIGHT_ONE - {1'b0, alpha_eff};

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_DECODE:
            begin
                mul_a = MUL_A_W'(gyro_reg);
                mul_b = {2'b00, dt_reg};
            end
            ST_MIX1:
            begin
                mul_a = sum_reg;
                mul_b = {2'b00, alpha_eff};
            end
            ST_MIX2:
            begin
                mul_a = MUL_A_W'(accel_reg);
                mul_b = {1'b0, accel_weight};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Gyro increment (floor of the Q.16 product) added to the pitch.
    assign sum_wide = WIDE_W'(pitch_reg) + WIDE_W'($signed(prod_reg[MUL_P_W-1:16]));

    // Final blend sum; its top bits are the floor of the shift by 16.
    assign mix = acc_reg + ACC_W'(prod_reg);

    // Gate arming and test.
    assign norm_err      = (norm_reg >= NORM_ONE) ? (norm_reg - NORM_ONE) : (NORM_ONE - norm_reg);
    assign deadline_cand = (norm_err > thresh_reg) ? (now_reg + TIME_W'(hold_reg)) : deadline_reg;
    assign hold_active   = (action_reg == ACT_GATED) && (now_reg < deadline_cand);

    assign dt_bad = (dt_reg == '0) || (dt_reg > DT_LIMIT);

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        pitch_next      = pitch_reg;
        deadline_next   = deadline_reg;
        alpha_next      = alpha_reg;
        thresh_next     = thresh_reg;
        hold_next       = hold_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        sum_next        = sum_reg;
        gyro_flag_next  = gyro_flag_reg;
        fault_flag_next = fault_flag_reg;

        // The output beat leaves when it is taken.
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        // Configuration writes; unknown indexes are dropped.
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ALPHA:  alpha_next  = cfg_data;
                CFG_THRESH: thresh_next = cfg_data;
                CFG_HOLD:   hold_next   = cfg_data;
                default:    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                gyro_flag_next  = 1'b0;
                fault_flag_next = 1'b0;
                prod_next       = mul_p;
                case (action_reg)
                    ACT_LOAD:
                    begin
                        pitch_next    = start_reg;
                        deadline_next = '0;
                        state_next    = ST_OUT;
                    end
                    ACT_GATED, ACT_PLAIN:
                    begin
                        if (dt_bad)
                        begin
                            pitch_next      = accel_reg;
                            fault_flag_next = 1'b1;
                            state_next      = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_SUM;
                        end
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_SUM:
            begin
                sum_next = sum_wide[MUL_A_W-1:0];
                if (action_reg == ACT_GATED)
                    deadline_next = deadline_cand;
                if (hold_active)
                begin
                    pitch_next     = sat_pitch(sum_wide);
                    gyro_flag_next = 1'b1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    state_next = ST_MIX1;
                end
            end
            ST_MIX1:
            begin
                acc_next   = ACC_W'(mul_p);
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                prod_next  = mul_p;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                pitch_next = sat_pitch(mix[ACC_W-1:16]);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pitch_reg     <= '0;
            deadline_reg  <= '0;
            alpha_reg     <= ALPHA_DEFAULT;
            thresh_reg    <= 16'd410;
            hold_reg      <= 16'd200;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pitch_reg     <= pitch_next;
            deadline_reg  <= deadline_next;
            alpha_reg     <= alpha_next;
            thresh_reg    <= thresh_next;
            hold_reg      <= hold_next;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            action_reg <= action;
            gyro_reg   <= gyro_rate;
            accel_reg  <= accel_pitch;
            dt_reg     <= step_time;
            norm_reg   <= accel_norm;
            now_reg    <= now_time;
            start_reg  <= start_pitch;
        end
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        sum_reg        <= sum_next;
        gyro_flag_reg  <= gyro_flag_next;
        fault_flag_reg <= fault_flag_next;
        if (state_reg == ST_OUT && out_free)
        begin
            pitch_out_reg <= pitch_reg;
            gyro_out_reg  <= gyro_flag_reg;
            fault_out_reg <= fault_flag_reg;
        end
    end

endmodule

### rtl/gcpf_checker.sv
`timescale 1ns / 1ps

module gcpf_sva (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [gcpf_pkg::PITCH_W-1:0] pitch_estimate,
    input logic                                gyro_only,
    input logic                                interval_fault
);

    // A waiting output beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    // The two result flags never both show on one beat.
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(gyro_only && interval_fault))
        else $error("gyro_only and interval_fault both set");

    // After an input beat the block works on it and takes no other.
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in flight");

    // No result can appear in the cycle straight after an input beat.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind gated_complementary_pitch_filter gcpf_sva u_gcpf_sva (.*);
